// File: design/bfsf_pkg.sv
// shared types, codes and constants of the blended frame store span fill engine
`default_nettype none
package bfsf_pkg;

   localparam int CFG_W       = 10;
   localparam int FULL_ADDR_W = 21;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_BLEND = 2'd2;
   localparam logic [1:0] CMD_FILL  = 2'd3;

   localparam logic [1:0] CSR_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_HEIGHT   = 2'd1;
   localparam logic [1:0] CSR_OFFSET_X = 2'd2;
   localparam logic [1:0] CSR_OFFSET_Y = 2'd3;

   localparam logic [9:0] WIDTH_RESET  = 10'd320;
   localparam logic [8:0] HEIGHT_RESET = 9'd240;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] x_start;
      logic signed [15:0] y_start;
      logic signed [15:0] x_stop;
      logic signed [15:0] y_stop;
      logic [31:0]        argb_color;
   } req_type;

   typedef struct packed {
      logic [31:0] read_color;
      logic        inside_res;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PIX_ADDR,
      S_BLEND_WR,
      S_FILL_SETUP,
      S_FILL_ADDR,
      S_FILL_WR,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

// File: design/bfsf_blend.sv
// per channel alpha blend of a foreground colour onto a stored pixel
`default_nettype none
module bfsf_blend (
   input  wire logic [31:0] fg,
   input  wire logic [31:0] bg,
   output logic      [31:0] px
);
   import bfsf_pkg::*;

   logic [7:0]  alpha;
   logic [7:0]  alpha_inv;
   logic [23:0] mixed;

   assign alpha     = fg[31:24];
   assign alpha_inv = ALPHA_OPAQUE - alpha;

   always_comb begin
      logic [15:0] sum;
      mixed = '0;
      for (int c = 0; c < 3; c++) begin
         sum = 16'(fg[c*8 +: 8] * alpha) + 16'(bg[c*8 +: 8] * alpha_inv);
         mixed[c*8 +: 8] = sum[15:8];
      end
   end

   always_comb begin
      if (alpha == ALPHA_OPAQUE) begin
         px = fg;
      end else if (alpha == ALPHA_CLEAR) begin
         px = bg;
      end else begin
         px = {alpha, mixed};
      end
   end

endmodule
`default_nettype wire

// File: design/blended_framebuffer_span_fill.sv
// top level: frame store, address unit and command sequencer of the span fill engine
//
// requests arrive on req_valid/req_ready/req_data and each one yields exactly one
// response on rsp_valid/rsp_ready/rsp_data. req_ready is high only while the
// sequencer is idle; one request is worked on at a time.
// a pixel read or write passes through an address state and then the response state;
// a pixel blend adds a blend write state between them, since the single ported frame
// store and the shared address multiplier set this order.
// a rectangle fill passes through a setup state, then the address state for each
// covered pixel for opaque colour, or the address and write states for each pixel
// when blending (read then write of the store), then the response state.
// csr_we/csr_index/csr_wdata write the canvas width, height and offsets; write
// them only while no request is in flight.
// the response sits in an output register: a stalled receiver holds it there,
// and the sequencer waits with the next finished response until it is taken.
// synchronous reset returns the sequencer to idle, drops any pending response and
// restores the canvas registers; frame store contents are undefined until written
// and no clearing pass runs.
`default_nettype none
module blended_framebuffer_span_fill #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire bfsf_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output bfsf_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [bfsf_pkg::CFG_W-1:0] csr_wdata
);
   import bfsf_pkg::*;

   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int CMP_W       = (ADDR_W + 1 > FULL_ADDR_W) ? ADDR_W + 1 : FULL_ADDR_W;
   localparam logic [CMP_W-1:0] STORE_LIMIT = CMP_W'(STORE_WORDS);

   logic [31:0] mem [STORE_WORDS];

   state_type state_ff, state_in;

   logic [9:0] width_ff;
   logic [8:0] height_ff;
   logic [8:0] offset_x_ff;
   logic [7:0] offset_y_ff;

   req_type     req_ff;
   logic        inside_ff, inside_in;
   logic        ok_ff, ok_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [31:0] rd_data_ff;

   logic [9:0] x_cur_ff, x_lo_ff, x_hi_ff;
   logic [8:0] y_cur_ff, y_hi_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        load_rsp;
   logic        pix_latch;
   logic        fill_start;
   logic        step;

   // shared address unit
   logic [9:0]  xv;
   logic [8:0]  yv;
   logic [9:0]  row;
   logic [19:0] prod;
   logic [10:0] col;
   logic [FULL_ADDR_W-1:0] addr_full;
   logic [CMP_W-1:0]  addr_cmp;
   logic [ADDR_W-1:0] addr_idx;
   logic        in_range;
   logic        pix_inside;

   // fill setup
   logic signed [15:0] lo_s, hi_s;
   logic signed [16:0] lo_e, hi_e, lo_c, hi_c, w_e, h_e, ys_e, ye_e, y0_c, y1_c;
   logic        fill_empty;

   // span stepping
   logic [10:0] x_next;
   logic [9:0]  y_next;
   logic        row_end;
   logic        last_px;

   logic        mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0] mem_wdata;
   logic [31:0] blend_px;
   logic        direct;

   bfsf_blend u_blend (
      .fg (req_ff.argb_color),
      .bg (rd_data_ff),
      .px (blend_px)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign direct    = (req_ff.argb_color[31:24] == ALPHA_OPAQUE);

   assign xv        = (state_ff == S_PIX_ADDR) ? req_ff.x_start[9:0] : x_cur_ff;
   assign yv        = (state_ff == S_PIX_ADDR) ? req_ff.y_start[8:0] : y_cur_ff;
   assign row       = {1'b0, yv} + {2'b00, offset_y_ff};
   assign prod      = row * width_ff;
   assign col       = {1'b0, xv} + {2'b00, offset_x_ff};
   assign addr_full = FULL_ADDR_W'(prod) + FULL_ADDR_W'(col);
   assign addr_cmp  = CMP_W'(addr_full);
   assign addr_idx  = addr_cmp[ADDR_W-1:0];
   assign in_range  = (addr_cmp < STORE_LIMIT);

   assign pix_inside = !req_ff.x_start[15] && !req_ff.y_start[15]
                    && (req_ff.x_start[14:0] < 15'(width_ff))
                    && (req_ff.y_start[14:0] < 15'(height_ff));

   assign lo_s  = (req_ff.x_start < req_ff.x_stop) ? req_ff.x_start : req_ff.x_stop;
   assign hi_s  = (req_ff.x_start < req_ff.x_stop) ? req_ff.x_stop : req_ff.x_start;
   assign lo_e  = {lo_s[15], lo_s};
   assign hi_e  = {hi_s[15], hi_s};
   assign w_e   = {7'b0, width_ff};
   assign h_e   = {8'b0, height_ff};
   assign ys_e  = {req_ff.y_start[15], req_ff.y_start};
   assign ye_e  = {req_ff.y_stop[15], req_ff.y_stop};
   assign lo_c  = (lo_e < 17'sd0) ? 17'sd0 : ((lo_e > w_e) ? w_e : lo_e);
   assign hi_c  = (hi_e > w_e) ? w_e : hi_e;
   assign y0_c  = (ys_e < 17'sd0) ? 17'sd0 : ys_e;
   assign y1_c  = (ye_e > h_e) ? h_e : ye_e;
   assign fill_empty = (req_ff.argb_color[31:24] == ALPHA_CLEAR)
                    || (hi_c <= lo_c) || (y1_c <= y0_c);

   assign x_next  = {1'b0, x_cur_ff} + 11'd1;
   assign y_next  = {1'b0, y_cur_ff} + 10'd1;
   assign row_end = (x_next == {1'b0, x_hi_ff});
   assign last_px = row_end && (y_next == {1'b0, y_hi_ff});

   always_comb begin
      state_in   = state_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      mem_addr   = addr_idx;
      mem_wdata  = req_ff.argb_color;
      inside_in  = inside_ff;
      ok_in      = ok_ff;
      pix_latch  = 1'b0;
      fill_start = 1'b0;
      step       = 1'b0;
      load_rsp   = 1'b0;
      rsp_in.read_color = (req_ff.cmd == CMD_READ && ok_ff) ? rd_data_ff : 32'h0;
      rsp_in.inside_res = (req_ff.cmd != CMD_FILL) && inside_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.cmd == CMD_FILL) ? S_FILL_SETUP : S_PIX_ADDR;
            end
         end
         S_PIX_ADDR: begin
            pix_latch = 1'b1;
            inside_in = pix_inside;
            ok_in     = pix_inside && in_range;
            if (ok_in && req_ff.cmd == CMD_WRITE) begin
               mem_we = 1'b1;
            end
            if (ok_in && (req_ff.cmd == CMD_READ || req_ff.cmd == CMD_BLEND)) begin
               mem_re = 1'b1;
            end
            state_in = (req_ff.cmd == CMD_BLEND) ? S_BLEND_WR : S_RESP;
         end
         S_BLEND_WR: begin
            mem_addr  = addr_ff;
            mem_wdata = blend_px;
            mem_we    = ok_ff;
            state_in  = S_RESP;
         end
         S_FILL_SETUP: begin
            fill_start = !fill_empty;
            state_in   = fill_empty ? S_RESP : S_FILL_ADDR;
         end
         S_FILL_ADDR: begin
            pix_latch = 1'b1;
            ok_in     = in_range;
            if (direct) begin
               mem_we   = in_range;
               step     = 1'b1;
               state_in = last_px ? S_RESP : S_FILL_ADDR;
            end else begin
               mem_re   = in_range;
               state_in = S_FILL_WR;
            end
         end
         S_FILL_WR: begin
            mem_addr  = addr_ff;
            mem_wdata = blend_px;
            mem_we    = ok_ff;
            step      = 1'b1;
            state_in  = last_px ? S_RESP : S_FILL_ADDR;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RESET;
         height_ff   <= HEIGHT_RESET;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:    width_ff    <= csr_wdata;
            CSR_HEIGHT:   height_ff   <= csr_wdata[8:0];
            CSR_OFFSET_X: offset_x_ff <= csr_wdata[8:0];
            CSR_OFFSET_Y: offset_y_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (pix_latch) begin
         inside_ff <= inside_in;
         ok_ff     <= ok_in;
         addr_ff   <= addr_idx;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if (fill_start) begin
         x_lo_ff  <= lo_c[9:0];
         x_hi_ff  <= hi_c[9:0];
         x_cur_ff <= lo_c[9:0];
         y_cur_ff <= y0_c[8:0];
         y_hi_ff  <= y1_c[8:0];
      end else if (step) begin
         if (row_end) begin
            x_cur_ff <= x_lo_ff;
            y_cur_ff <= y_next[8:0];
         end else begin
            x_cur_ff <= x_next[9:0];
         end
      end
   end

   // frame store, single port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("sequencer stayed idle after a request");

   a_direct_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == S_PIX_ADDR || state_ff == S_FILL_ADDR)) |-> in_range)
      else $error("frame store write beyond the store");

   a_span_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FILL_ADDR) |-> (x_cur_ff < x_hi_ff && y_cur_ff < y_hi_ff
                                     && x_lo_ff <= x_cur_ff))
      else $error("fill position outside its span");

   a_fill_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && req_ff.cmd == CMD_FILL) |=>
         (rsp_ff.read_color == 32'h0 && !rsp_ff.inside_res))
      else $error("fill response carries data");

   a_blend_write_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLEND_WR) |-> (req_ff.cmd == CMD_BLEND && $past(state_ff) == S_PIX_ADDR))
      else $error("blend write without a blend request");

endmodule
`default_nettype wire
